FILE: sv/icm_pkg.sv
// shared types, widths and codes for the iou cost matrix block
`default_nettype none

package icm_pkg;

    localparam int FUNC_W         = 2;
    localparam int COORD_W        = 14;
    localparam int SIZE_W         = 13;
    localparam int BOX_W          = 2 * COORD_W + 2 * SIZE_W;
    localparam int S_TDATA_W      = ((BOX_W + 7) / 8) * 8;
    localparam int TRACK_INDEX_W  = 6;
    localparam int COST_W         = 17;
    localparam int M_FIELDS_W     = TRACK_INDEX_W + COST_W;
    localparam int M_TDATA_W      = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int AREA_W         = 2 * SIZE_W;
    localparam int UNION_W        = AREA_W + 1;
    localparam int MAX_TRACKS_DEF = 64;

    localparam logic [COST_W-1:0] COST_ONE = COST_W'(65536);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2
    } func_t;

    // left in the lowest bits, height in the highest
    typedef struct packed {
        logic        [SIZE_W-1:0]  height;
        logic        [SIZE_W-1:0]  width;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] left;
    } box_t;

endpackage

`default_nettype wire

FILE: sv/iou_cost_matrix_unit.sv
// iou cost matrix top level: track store, geometry, serial area and cost units
//
// usage: beats on the s_ channel carry a function code in s_tuser and a box
// in s_tdata. clear empties the track store, append stores one track box
// (dropped when the store is full), query compares a detection box against
// every stored track and returns one m_ beat per track in index order, with
// m_tlast on the final track. cost = 65536 - floor(inter * 65536 / union),
// 65536 when the union is zero.
// clear and append are done as the beat is accepted. a query walks each stored
// track through the ram read, geometry, three parallel bit-serial area
// multipliers, union, the bit-serial divider, then the output
// register. s_tready is high only between items; a query on an empty store
// returns nothing. the output register lets the next track start while a
// result waits, and a stalled m_ side holds the engine before the next load.
// reset clears the track count, the state machine and the output valid; the
// ram needs no clearing since only written entries are ever read.
`default_nettype none

module iou_cost_matrix_unit
    import icm_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input beats
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // box_left, box_top, box_width, box_height
    input  wire logic [FUNC_W-1:0]    s_tuser,   // func
    // result beats
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // track_index, cost
    output logic                      m_tlast    // last
);

    localparam int IDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
    localparam int EDGE_W = COORD_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_GEOM,
        S_MUL,
        S_UNION,
        S_DIV,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    box_t               det_reg, det_next;
    logic               zero_reg, zero_next;
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [COST_W-1:0]  out_cost_reg, out_cost_next;
    logic               out_last_reg, out_last_next;

    logic               in_fire;
    func_t              func;
    box_t               in_box;
    logic               ram_we;
    logic [BOX_W-1:0]   ram_rdata;
    box_t               trk;

    // geometry of the overlap
    logic signed [COORD_W-1:0] x1, y1;
    logic signed [EDGE_W-1:0]  a_r, b_r, a_b, b_b, x2, y2, dx, dy;
    logic [SIZE_W-1:0]         iw, ih;

    // serial units
    logic               mul_start;
    logic               mul_trk_done, mul_det_done, mul_int_done, mul_done;
    logic [AREA_W-1:0]  area_trk, area_det, area_int;
    logic [UNION_W-1:0] uni;
    logic               div_start, div_done;
    logic [COST_W-1:0]  quo;

    logic               out_load;
    logic               is_last;

    assign in_fire = s_tvalid && s_tready;
    assign func    = func_t'(s_tuser);
    assign in_box  = box_t'(s_tdata[BOX_W-1:0]);
    assign trk     = box_t'(ram_rdata);

    // track store: written at the fill count, read at the walk index
    icm_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_TRACKS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (s_tdata[BOX_W-1:0]),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // overlap edges: max of lefts/tops, min of rights/bottoms
    always_comb begin
        x1  = (trk.left > det_reg.left) ? trk.left : det_reg.left;
        y1  = (trk.top > det_reg.top) ? trk.top : det_reg.top;
        a_r = {{2{trk.left[COORD_W-1]}}, trk.left} + {3'b000, trk.width};
        b_r = {{2{det_reg.left[COORD_W-1]}}, det_reg.left} + {3'b000, det_reg.width};
        a_b = {{2{trk.top[COORD_W-1]}}, trk.top} + {3'b000, trk.height};
        b_b = {{2{det_reg.top[COORD_W-1]}}, det_reg.top} + {3'b000, det_reg.height};
        x2  = (a_r < b_r) ? a_r : b_r;
        y2  = (a_b < b_b) ? a_b : b_b;
        dx  = x2 - {{2{x1[COORD_W-1]}}, x1};
        dy  = y2 - {{2{y1[COORD_W-1]}}, y1};
        // empty overlap when either extent is zero or negative
        iw  = (!dx[EDGE_W-1] && (dx != '0)) ? dx[SIZE_W-1:0] : '0;
        ih  = (!dy[EDGE_W-1] && (dy != '0)) ? dy[SIZE_W-1:0] : '0;
    end

    // three areas in parallel, one multiplier bit per cycle
    icm_mul #(.W(SIZE_W)) u_mul_trk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (trk.width),
        .b       (trk.height),
        .done    (mul_trk_done),
        .product (area_trk)
    );

    icm_mul #(.W(SIZE_W)) u_mul_det (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (det_reg.width),
        .b       (det_reg.height),
        .done    (mul_det_done),
        .product (area_det)
    );

    icm_mul #(.W(SIZE_W)) u_mul_int (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (iw),
        .b       (ih),
        .done    (mul_int_done),
        .product (area_int)
    );

    assign mul_done = mul_trk_done && mul_det_done && mul_int_done;

    // union never drops below the intersection, so the quotient fits 0..65536
    assign uni = UNION_W'(area_trk) + UNION_W'(area_det) - UNION_W'(area_int);

    icm_div #(
        .NUM_W (UNION_W),
        .QUO_W (COST_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (UNION_W'(area_int)),
        .den     (uni),
        .done    (div_done),
        .quo     (quo)
    );

    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || m_tready);
    assign is_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        det_next       = det_reg;
        zero_next      = zero_reg;
        out_idx_next   = out_idx_reg;
        out_cost_next  = out_cost_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ram_we         = 1'b0;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    case (func)
                        FUNC_CLEAR: begin
                            count_next = '0;
                        end
                        FUNC_APPEND: begin
                            // full store drops the box
                            if (count_reg < CNT_W'(MAX_TRACKS)) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FUNC_QUERY: begin
                            det_next = in_box;
                            if (count_reg != '0) begin
                                idx_next   = '0;
                                state_next = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                state_next = S_GEOM;
            end
            S_GEOM: begin
                mul_start  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                if (mul_done) begin
                    state_next = S_UNION;
                end
            end
            S_UNION: begin
                div_start  = 1'b1;
                zero_next  = (uni == '0);
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    out_idx_next   = idx_reg;
                    out_cost_next  = zero_reg ? COST_ONE : (COST_ONE - quo);
                    out_last_next  = is_last;
                    if (is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
        det_reg      <= det_next;
        zero_reg     <= zero_next;
        out_idx_reg  <= out_idx_next;
        out_cost_reg <= out_cost_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_cost_reg, TRACK_INDEX_W'(out_idx_reg)});
    assign m_tlast  = out_last_reg;

    // fill count never passes the store depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_TRACKS))
        else $error("track count above store depth");

    // the walk only visits written entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("track walk past fill count");

    // a result never exceeds a cost of one
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_cost_reg <= COST_ONE))
        else $error("cost out of range");

    // the divider only starts once all three areas are in
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> $past(mul_done))
        else $error("division started before areas were ready");

endmodule

`default_nettype wire

FILE: sv/icm_ram.sv
// generic single write port ram with registered read
`default_nettype none

module icm_ram
    import icm_pkg::*;
#(
    parameter int WIDTH = BOX_W,
    parameter int DEPTH = MAX_TRACKS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/icm_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module icm_mul
    import icm_pkg::*;
#(
    parameter int W = SIZE_W
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    output logic                done,
    output logic [2*W-1:0]      product
);

    localparam int CW = $clog2(W + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [2*W-1:0] mcand_reg, mcand_next;
    logic [W-1:0]   mplier_reg, mplier_next;
    logic [2*W-1:0] prod_reg, prod_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = CW'(W);
            mcand_next  = (2*W)'(a);
            mplier_next = b;
            prod_next   = '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                prod_next = prod_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[2*W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[W-1:1]};
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

FILE: sv/icm_div.sv
// restoring divider, one quotient bit per cycle; expects num below twice den
`default_nettype none

module icm_div
    import icm_pkg::*;
#(
    parameter int NUM_W = UNION_W,
    parameter int QUO_W = COST_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [NUM_W-1:0] den,
    output logic                  done,
    output logic [QUO_W-1:0]      quo
);

    localparam int CW = $clog2(QUO_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             first_reg, first_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] den_reg, den_next;
    logic [QUO_W-1:0] quo_reg, quo_next;

    logic [NUM_W:0]   shifted;
    logic [NUM_W+1:0] diff;
    logic             ge;

    // first step takes the integer bit, later steps shift the remainder
    assign shifted = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign ge      = !diff[NUM_W+1];

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        if (start) begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            cnt_next   = CW'(QUO_W);
            rem_next   = num;
            den_next   = den;
            quo_next   = '0;
        end else if (busy_reg) begin
            first_next = 1'b0;
            rem_next   = ge ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
            quo_next   = {quo_reg[QUO_W-2:0], ge};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

FILE: verif/iou_cost_checker.sv
// watches both channels of the iou cost matrix block, predicts each cost beat and compares
module iou_cost_checker
    import icm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // box_left, box_top, box_width, box_height
    input  wire logic [FUNC_W-1:0]    s_tuser,   // func
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,   // track_index, cost
    input  wire logic                 m_tlast,   // last
    output int                        mismatches,
    output int                        costs_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [TRACK_INDEX_W-1:0] index;
        logic [COST_W-1:0]        cost;
        logic                     last;
    } cost_beat_t;

    box_t        track_store [MAX_TRACKS_DEF];
    int unsigned track_total = 0;
    cost_beat_t  expected_costs [$];
    int          fail_count = 0;

    // 1 - iou in q1.16, exact integer arithmetic
    function automatic logic [COST_W-1:0] iou_cost(box_t trk, box_t det);
        longint t_l, t_t, d_l, d_t;
        longint lo_x, lo_y, hi_x, hi_y;
        longint inter, uni, ratio;
        t_l  = longint'(trk.left);
        t_t  = longint'(trk.top);
        d_l  = longint'(det.left);
        d_t  = longint'(det.top);
        lo_x = (t_l > d_l) ? t_l : d_l;
        lo_y = (t_t > d_t) ? t_t : d_t;
        hi_x = t_l + longint'(trk.width);
        if (d_l + longint'(det.width) < hi_x) hi_x = d_l + longint'(det.width);
        hi_y = t_t + longint'(trk.height);
        if (d_t + longint'(det.height) < hi_y) hi_y = d_t + longint'(det.height);
        inter = 0;
        if (hi_x > lo_x && hi_y > lo_y) inter = (hi_x - lo_x) * (hi_y - lo_y);
        uni = longint'(trk.width) * longint'(trk.height)
            + longint'(det.width) * longint'(det.height) - inter;
        if (uni == 0) return COST_ONE;
        ratio = (inter << 16) / uni;
        if (ratio > longint'(COST_ONE)) ratio = longint'(COST_ONE);
        return COST_W'(longint'(COST_ONE) - ratio);
    endfunction

    task automatic flag_beat(string what, cost_beat_t want, cost_beat_t got);
        if (fail_count < 10) begin
            $display("%t %s: expected index %0d cost %0d last %0b, %s",
                     $realtime, what, want.index, want.cost, want.last,
                     $sformatf("got index %0d cost %0d last %0b",
                               got.index, got.cost, got.last));
        end
        fail_count++;
    endtask

    always @(posedge aclk) begin : monitor
        box_t       in_box;
        cost_beat_t got;
        cost_beat_t want;
        if (!aresetn) begin
            track_total = 0;
            expected_costs.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                in_box = box_t'(s_tdata[BOX_W-1:0]);
                case (s_tuser)
                    FUNC_CLEAR: begin
                        track_total = 0;
                    end
                    FUNC_APPEND: begin
                        // a full store drops the box
                        if (track_total < MAX_TRACKS_DEF) begin
                            track_store[track_total] = in_box;
                            track_total++;
                        end
                    end
                    FUNC_QUERY: begin
                        for (int i = 0; i < track_total; i++) begin
                            want.index = TRACK_INDEX_W'(i);
                            want.cost  = iou_cost(track_store[i], in_box);
                            want.last  = (i + 1 == track_total);
                            expected_costs = {expected_costs, want};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.index = m_tdata[TRACK_INDEX_W-1:0];
                got.cost  = m_tdata[TRACK_INDEX_W +: COST_W];
                got.last  = m_tlast;
                if (expected_costs.size() == 0) begin
                    want = '{default: '0};
                    flag_beat("unexpected beat", want, got);
                end else begin
                    want = expected_costs.pop_front();
                    if (got.index !== want.index || got.cost !== want.cost
                        || got.last !== want.last) begin
                        flag_beat("cost mismatch", want, got);
                    end
                end
            end
        end
        mismatches    <= fail_count;
        costs_pending <= expected_costs.size();
    end

endmodule

FILE: verif/testbench.sv
// top of the iou cost matrix testbench: clock, reset, stimulus, ready pattern and verdict
module testbench
    import icm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // the selector value the block has no use for
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // box_left, box_top, box_width, box_height
    logic [FUNC_W-1:0]    s_tuser;   // func
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // track_index, cost
    logic                 m_tlast;   // last

    int mismatches;
    int costs_pending;

    // idling percentages of the current phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // beats the block acts on; ignored selector beats are left out
    int items_sent     = 0;

    always #5ns aclk = ~aclk;

    iou_cost_matrix_unit #(
        .MAX_TRACKS (MAX_TRACKS_DEF)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    iou_cost_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .costs_pending (costs_pending)
    );

    function automatic box_t box_of(int l, int t, int w, int h);
        box_t b;
        b.left   = COORD_W'(l);
        b.top    = COORD_W'(t);
        b.width  = SIZE_W'(w);
        b.height = SIZE_W'(h);
        return b;
    endfunction

    // mostly boxes clustered around the origin so that pairs overlap,
    // the rest spread over the full field ranges, the edges and zero sizes
    function automatic box_t random_box();
        box_t b;
        int   pick;
        pick = $urandom_range(99);
        b = box_of(int'($urandom_range(80)) - 40, int'($urandom_range(80)) - 40,
                   $urandom_range(80), $urandom_range(80));
        if (pick >= 60 && pick < 80) begin
            b = box_t'($urandom);
            b.top    = COORD_W'($urandom);
            b.width  = SIZE_W'($urandom);
            b.height = SIZE_W'($urandom);
        end else if (pick >= 80 && pick < 90) begin
            // right or bottom edge past the coordinate range, or the far negative corner
            b.left   = $urandom_range(1) ? COORD_W'(8191 - $urandom_range(15))
                                         : COORD_W'(-8192 + int'($urandom_range(15)));
            b.top    = $urandom_range(1) ? COORD_W'(8191 - $urandom_range(15))
                                         : COORD_W'(-8192 + int'($urandom_range(15)));
            b.width  = SIZE_W'(8191 - $urandom_range(15));
            b.height = SIZE_W'(8191 - $urandom_range(15));
        end else if (pick >= 90) begin
            // zero area box
            if ($urandom_range(1)) b.width = '0;
            if ($urandom_range(1)) b.height = '0;
            else b.width = '0;
        end
        return b;
    endfunction

    // presents one beat at the falling edge and holds it until accepted;
    // valid stays high when the next beat follows without a gap
    task automatic send_box(input logic [FUNC_W-1:0] func, input box_t b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(b);
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        if (func != FUNC_UNUSED) items_sent++;
    endtask

    // receiver side ready pattern
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin : stimulus
        box_t b;
        box_t det;
        box_t last_track;
        int   random_start;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = FUNC_CLEAR;
        last_track = box_of(0, 0, 100, 50);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, no idling
        send_box(FUNC_QUERY, box_of(0, 0, 10, 10));          // empty store
        send_box(FUNC_UNUSED, box_of(5, 5, 5, 5));           // ignored selector
        send_box(FUNC_APPEND, box_of(0, 0, 0, 0));
        send_box(FUNC_QUERY, box_of(0, 0, 0, 0));            // zero union
        send_box(FUNC_APPEND, box_of(-8192, -8192, 8191, 8191));
        send_box(FUNC_APPEND, box_of(8191, 8191, 8191, 8191));
        send_box(FUNC_APPEND, box_of(-1, -1, 8191, 8191));   // all ones
        send_box(FUNC_APPEND, box_of(0, 0, 100, 50));
        send_box(FUNC_QUERY, box_of(0, 0, 100, 50));         // identical box
        send_box(FUNC_QUERY, box_of(8191, -8192, 8191, 8191));
        send_box(FUNC_QUERY, box_of(100, 0, 10, 50));        // edges touch the 100x50 track only
        send_box(FUNC_QUERY, box_of(2000, 2000, 30, 30));    // disjoint from the 100x50 track
        send_box(FUNC_QUERY, box_of(50, 25, 100, 50));       // partial overlap
        send_box(FUNC_CLEAR, box_of(-1, -1, 8191, 8191));
        send_box(FUNC_QUERY, box_of(0, 0, 100, 50));         // store cleared
        send_box(FUNC_APPEND, box_of(-20, 10, 40, 0));
        send_box(FUNC_QUERY, box_of(-20, 10, 40, 7));        // single track, zero area one
        send_box(FUNC_UNUSED, box_of(-8192, 8191, 0, 8191));
        send_box(FUNC_CLEAR, box_of(0, 0, 0, 0));

        // random part in four idling phases
        random_start = items_sent;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 81;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            if (phase == 2) begin
                // fill the store past capacity, the surplus appends are dropped
                send_box(FUNC_CLEAR, random_box());
                repeat (MAX_TRACKS_DEF + 2) begin
                    b = random_box();
                    send_box(FUNC_APPEND, b);
                end
                last_track = b;
                send_box(FUNC_QUERY, random_box());
                send_box(FUNC_QUERY, box_of(0, 0, 40, 40));
            end
            while (items_sent < random_start + 50 * (phase + 1)) begin
                if ($urandom_range(3) == 0) send_box(FUNC_CLEAR, random_box());
                repeat ($urandom_range(1, 6)) begin
                    b = random_box();
                    send_box(FUNC_APPEND, b);
                    last_track = b;
                end
                repeat ($urandom_range(1, 3)) begin
                    det = random_box();
                    // a detection close to a stored track gives low costs
                    if ($urandom_range(3) == 0) begin
                        det = last_track;
                        det.left = det.left + COORD_W'($urandom_range(6)) - COORD_W'(3);
                        det.top  = det.top + COORD_W'($urandom_range(6)) - COORD_W'(3);
                    end
                    send_box(FUNC_QUERY, det);
                end
                if ($urandom_range(9) == 0) send_box(FUNC_UNUSED, random_box());
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        // drain, then give a stray beat time to show up
        while (costs_pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
sv/icm_pkg.sv
sv/icm_ram.sv
sv/icm_mul.sv
sv/icm_div.sv
sv/iou_cost_matrix_unit.sv
verif/iou_cost_checker.sv
verif/testbench.sv
